/* src/abarq_pkg.sv */
// Shared types, constants and codes for the alternating-bit ARQ sender.
`default_nettype none
package abarq_pkg;

  // Field widths.
  localparam int NODE_W    = 5;
  localparam int ROW_W     = 3;
  localparam int TMO_W     = 16;
  localparam int CNT_W     = 16;
  localparam int DELAY_W   = 24;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Grid defaults and the fixed destination offset.
  localparam int GRID_NODES_DEF   = 25;
  localparam int GRID_COLUMNS_DEF = 5;
  localparam int DEST_OFFSET      = 19;

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  // Register reset values.
  localparam logic [NODE_W-1:0] NODE_RST  = '0;
  localparam logic [TMO_W-1:0]  TMO0_RST  = 16'd500;
  localparam logic [TMO_W-1:0]  TMO1_RST  = 16'd2000;
  localparam logic [CNT_W-1:0]  LIMIT_RST = 16'd19000;

  // Event codes.
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TMO0  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TMO1  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [TMO_W-1:0]  timeout_zero;
    logic [TMO_W-1:0]  timeout_one;
    logic [CNT_W-1:0]  message_limit;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
  } dest_t;

  typedef struct packed {
    logic               frame_valid;
    logic               frame_seq;
    logic [NODE_W-1:0]  source_node;
    logic [NODE_W-1:0]  dest_node;
    logic [ROW_W-1:0]   dest_row;
    logic [ROW_W-1:0]   dest_col;
    logic [DELAY_W-1:0] added_delay_ms;
    logic [CNT_W-1:0]   delivered_count;
    logic               finished;
  } result_t;

endpackage
`default_nettype wire

/* src/alternating_bit_arq_sender_core.sv */
// Top level of the alternating-bit stop-and-wait ARQ sender.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   action, ack_seq
//   out_     output     out_valid/out_stall frame fields and counters
//   cfg_     input      cfg_valid/cfg_ready register index, write data
//
// One event is accepted every cycle while in_stall is low; each gives one
// result beat (input register, then result register after the state update).
// Synchronous reset clears the protocol state and loads register defaults.
// A stalled result holds; the input register keeps taking beats as long as
// the result register is free or drains in the same cycle.
`default_nettype none
module alternating_bit_arq_sender_core
  import abarq_pkg::*;
#(
  parameter int GRID_NODES   = GRID_NODES_DEF,
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Event channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ACT_W-1:0]      in_action,
  input  wire logic                  in_ack_seq,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_frame_valid,
  output logic                       out_frame_seq,
  output logic [NODE_W-1:0]          out_source_node,
  output logic [NODE_W-1:0]          out_dest_node,
  output logic [ROW_W-1:0]           out_dest_row,
  output logic [ROW_W-1:0]           out_dest_col,
  output logic [DELAY_W-1:0]         out_added_delay_ms,
  output logic [CNT_W-1:0]           out_delivered_count,
  output logic                       out_finished,
  // Configuration write channel.
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic             item_valid_r, item_valid_nxt;
  logic [ACT_W-1:0] action_r;
  logic             ack_seq_r;
  logic             in_take;
  logic             take;
  cfg_t             cfg;
  dest_t            dest;
  result_t          res;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  abarq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  abarq_dest_map #(
    .GRID_NODES   (GRID_NODES),
    .GRID_COLUMNS (GRID_COLUMNS)
  ) u_dest (
    .node (cfg.node_index),
    .dest (dest)
  );

  // Input register: stalls only when holding a beat that cannot move on.
  assign in_stall = item_valid_r && !take;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r  <= in_action;
      ack_seq_r <= in_ack_seq;
    end
  end

  abarq_proto u_proto (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid_r),
    .action     (action_r),
    .ack_seq    (ack_seq_r),
    .cfg        (cfg),
    .dest       (dest),
    .res_stall  (out_stall),
    .take       (take),
    .res_valid  (out_valid),
    .res        (res)
  );

  // Unpack the result beat onto its ports.
  assign out_frame_valid     = res.frame_valid;
  assign out_frame_seq       = res.frame_seq;
  assign out_source_node     = res.source_node;
  assign out_dest_node       = res.dest_node;
  assign out_dest_row        = res.dest_row;
  assign out_dest_col        = res.dest_col;
  assign out_added_delay_ms  = res.added_delay_ms;
  assign out_delivered_count = res.delivered_count;
  assign out_finished        = res.finished;

endmodule
`default_nettype wire

/* src/abarq_cfg_regs.sv */
// Configuration register file of the ARQ sender.
`default_nettype none
module abarq_cfg_regs
  import abarq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write beat; unknown indexes leave everything alone.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_NODE:  cfg_nxt.node_index    = wr_data[NODE_W-1:0];
        REG_TMO0:  cfg_nxt.timeout_zero  = wr_data[TMO_W-1:0];
        REG_TMO1:  cfg_nxt.timeout_one   = wr_data[TMO_W-1:0];
        REG_LIMIT: cfg_nxt.message_limit = wr_data[CNT_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_index    <= NODE_RST;
      cfg_r.timeout_zero  <= TMO0_RST;
      cfg_r.timeout_one   <= TMO1_RST;
      cfg_r.message_limit <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* src/abarq_dest_map.sv */
// Constant lookup from node index to destination node, row and column.
`default_nettype none
module abarq_dest_map
  import abarq_pkg::*;
#(
  parameter int GRID_NODES   = GRID_NODES_DEF,
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF
) (
  input  wire logic [NODE_W-1:0] node,
  output dest_t                  dest
);

  localparam int Entries = 2 ** NODE_W;

  dest_t map [Entries];

  // Each entry is worked out at elaboration from the grid shape.
  for (genvar g = 0; g < Entries; g++) begin : g_entry
    localparam int Dest = (g + DEST_OFFSET) % GRID_NODES;
    localparam int Row  = Dest / GRID_COLUMNS;
    localparam int Col  = Dest % GRID_COLUMNS;
    assign map[g].node = NODE_W'(Dest);
    assign map[g].row  = ROW_W'(Row);
    assign map[g].col  = ROW_W'(Col);
  end

  assign dest = map[node];

endmodule
`default_nettype wire

/* src/abarq_proto.sv */
// Protocol state update and result register of the ARQ sender.
`default_nettype none
module abarq_proto
  import abarq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire logic [ACT_W-1:0] action,
  input  wire logic             ack_seq,
  input  wire cfg_t             cfg,
  input  wire dest_t            dest,
  input  wire logic             res_stall,
  output logic                  take,
  output logic                  res_valid,
  output result_t               res
);

  logic               current_bit_r, current_bit_nxt;
  logic               awaiting_r, awaiting_nxt;
  logic               done_r, done_nxt;
  logic [TMO_W-1:0]   timer_r, timer_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               res_valid_r, res_valid_nxt;
  result_t            res_r, res_nxt;

  logic [TMO_W-1:0]   tmo_raw;
  logic [TMO_W-1:0]   tmo;
  logic [TMO_W-1:0]   timer_dec;
  logic [DELAY_W:0]   delay_sum;
  logic               frame;

  // The item moves on when the result register is empty or being drained.
  assign take = item_valid && (!res_valid_r || !res_stall);

  // Timeout for the current bit; zero acts as one.
  assign tmo_raw   = current_bit_r ? cfg.timeout_one : cfg.timeout_zero;
  assign tmo       = (tmo_raw == '0) ? TMO_W'(1) : tmo_raw;
  assign timer_dec = (timer_r != '0) ? timer_r - TMO_W'(1) : '0;
  assign delay_sum = {1'b0, delay_r} + (DELAY_W+1)'(tmo);

  // Event handling.
  always_comb begin
    current_bit_nxt = current_bit_r;
    awaiting_nxt    = awaiting_r;
    done_nxt        = done_r;
    timer_nxt       = timer_r;
    total_nxt       = total_r;
    delay_nxt       = delay_r;
    frame           = 1'b0;
    if (!done_r) begin
      case (action)
        ACT_TICK: begin
          if (awaiting_r) begin
            timer_nxt = timer_dec;
            if (timer_dec == '0) begin
              delay_nxt = delay_sum[DELAY_W] ? DELAY_MAX : delay_sum[DELAY_W-1:0];
              timer_nxt = tmo;
              frame     = 1'b1;
            end
          end
        end
        ACT_SEND: begin
          if (!awaiting_r) begin
            delay_nxt    = '0;
            timer_nxt    = tmo;
            awaiting_nxt = 1'b1;
            frame        = 1'b1;
          end
        end
        ACT_ACK: begin
          if (awaiting_r && (ack_seq == current_bit_r)) begin
            total_nxt       = total_r + CNT_W'(1);
            current_bit_nxt = ~current_bit_r;
            awaiting_nxt    = 1'b0;
            timer_nxt       = '0;
            if (total_nxt >= cfg.message_limit) begin
              done_nxt = 1'b1;
            end
          end
        end
        default: begin
          frame = 1'b0;
        end
      endcase
    end
  end

  // Result fields; frame fields read zero when nothing is sent.
  always_comb begin
    res_nxt                 = '0;
    res_nxt.frame_valid     = frame;
    if (frame) begin
      res_nxt.frame_seq      = current_bit_r;
      res_nxt.source_node    = cfg.node_index;
      res_nxt.dest_node      = dest.node;
      res_nxt.dest_row       = dest.row;
      res_nxt.dest_col       = dest.col;
      res_nxt.added_delay_ms = delay_nxt;
    end
    res_nxt.delivered_count = total_nxt;
    res_nxt.finished        = done_nxt;
  end

  // Result valid: loaded by a taken item, cleared when the beat leaves.
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (take) begin
      res_valid_nxt = 1'b1;
    end else if (!res_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_bit_r <= 1'b0;
      awaiting_r    <= 1'b0;
      done_r        <= 1'b0;
      timer_r       <= '0;
      total_r       <= '0;
      delay_r       <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        current_bit_r <= current_bit_nxt;
        awaiting_r    <= awaiting_nxt;
        done_r        <= done_nxt;
        timer_r       <= timer_nxt;
        total_r       <= total_nxt;
        delay_r       <= delay_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire
